### src/slcfr_pkg.sv
// Package for the sync, length and CRC frame receiver.
// Holds the phase and status codes, register indexes, the result struct and the
// byte-wide CRC-16 update. It depends on nothing else.
`timescale 1ns / 1ps

package slcfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h5A;
  localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h8005;

  localparam logic [BYTE_W-1:0] EXPECTED_TAG_RST    = 8'h00;
  localparam logic [LEN_W-1:0]  MAX_BODY_LENGTH_RST = 16'd2055;

  // Header byte positions, counted from the sync byte as position zero.
  localparam logic [LEN_W-1:0] HDR_TAG    = 16'd1;
  localparam logic [LEN_W-1:0] HDR_LEN_HI = 16'd2;
  localparam logic [LEN_W-1:0] HDR_LEN_LO = 16'd3;
  localparam logic [LEN_W-1:0] HDR_CRC_HI = 16'd4;
  localparam logic [LEN_W-1:0] HDR_CRC_LO = 16'd5;

  // Trailer byte positions.
  localparam logic [LEN_W-1:0] TRL_SEQ  = 16'd0;
  localparam logic [LEN_W-1:0] TRL_LAST = 16'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED_TAG    = 1'b0,
    REG_MAX_BODY_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_BODY    = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_WRONG_TAG    = 2'd1,
    ST_CRC_MISMATCH = 2'd2,
    ST_TOO_LONG     = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BODY   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  payload;
    status_t            status;
    logic [LEN_W-1:0]   length;
    logic [BYTE_W-1:0]  seq;
  } result_t;

  // One byte into a CRC-16 (poly 0x8005, MSB first, no reflection).
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### src/sync_length_crc_frame_receiver.sv
// Top level of the sync, length and CRC-16 frame receiver.
// Holds the input register and configuration registers; uses slcfr_pkg,
// slcfr_parser and slcfr_out_reg.
//
//   Channel  Handshake           Payload
//   -------  ------------------  ---------------------------------------------------
//   in       in_valid/in_stall   in_rx_byte
//   out      out_valid/out_stall out_result_kind, out_payload_byte, out_frame_status,
//                                out_body_length, out_sequence_number
//   cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// The block takes one byte per cycle while no result is held by out_stall. An accepted
// byte waits in the input register, where the parser and its byte-wide CRC update work
// on it, and any result it causes is registered in the result register for the out ports.
// Reset (rst_n low at a clock edge) returns the parser to sync hunting, empties both
// registers and restores the tag to 0 and the length limit to 2055.
// While out_stall holds a result, the input register keeps its byte and in_stall
// rises once that register is full; with out_stall low, bytes flow without a gap.
`timescale 1ns / 1ps

module sync_length_crc_frame_receiver
  import slcfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_result_kind,
  output logic [BYTE_W-1:0]    out_payload_byte,
  output logic [1:0]           out_frame_status,
  output logic [LEN_W-1:0]     out_body_length,
  output logic [BYTE_W-1:0]    out_sequence_number,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  // Input register: one received byte waiting for the parser.
  logic              in_vld_r, in_vld_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_take;
  logic              advance;

  // Configuration registers.
  logic [BYTE_W-1:0] tag_r;
  logic [LEN_W-1:0]  max_len_r;

  logic    res_vld;
  result_t res;
  logic    out_vld;
  result_t out_res;

  // The parser consumes the held byte whenever the result register is free or is
  // being emptied in this cycle.
  assign advance  = in_vld_r && (!out_vld || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // Configuration writes are always taken; the user makes them only while the block is idle; it is not enforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r     <= EXPECTED_TAG_RST;
      max_len_r <= MAX_BODY_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EXPECTED_TAG:    tag_r     <= cfg_data[BYTE_W-1:0];
        REG_MAX_BODY_LENGTH: max_len_r <= cfg_data[LEN_W-1:0];
        default:             tag_r     <= tag_r;
      endcase
    end
  end

  slcfr_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (advance),
    .rx_byte         (in_byte_r),
    .expected_tag    (tag_r),
    .max_body_length (max_len_r),
    .res_vld         (res_vld),
    .res             (res)
  );

  slcfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_vld),
    .res       (res),
    .out_stall (out_stall),
    .out_vld   (out_vld),
    .out_res   (out_res)
  );

  assign out_valid           = out_vld;
  assign out_result_kind     = out_res.kind;
  assign out_payload_byte    = out_res.payload;
  assign out_frame_status    = out_res.status;
  assign out_body_length     = out_res.length;
  assign out_sequence_number = out_res.seq;

`ifndef NO_ASSERTIONS
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld && out_stall)
    else $error("input stalled without a held byte and a blocked result");

  a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_stall |=> out_vld && !$past(advance))
    else $error("parser advanced while the result register was blocked");

  a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_stall |=> $stable(out_res))
    else $error("stalled result changed");
`endif

endmodule

### src/slcfr_parser.sv
// Frame parser of the sync, length and CRC frame receiver.
// Holds the phase, byte counter, header fields and running CRC; depends on slcfr_pkg.
`timescale 1ns / 1ps

module slcfr_parser
  import slcfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] expected_tag,
  input  logic [LEN_W-1:0]  max_body_length,
  output logic              res_vld,
  output result_t           res
);

  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [CRC_W-1:0]  rcrc_r, rcrc_nxt;
  logic              tag_ok_r, tag_ok_nxt;
  logic [BYTE_W-1:0] seq_r, seq_nxt;
  logic [CRC_W-1:0]  crc_byte;
  logic              hdr_done;
  logic              too_long;
  logic              body_done;
  logic              trl_done;

  assign crc_byte  = crc_feed(crc_r, rx_byte);
  assign hdr_done  = (cnt_r == HDR_CRC_LO);
  assign too_long  = (len_r > max_body_length);
  assign body_done = (cnt_r == {{(LEN_W-1){1'b0}}, 1'b1});
  assign trl_done  = (cnt_r == TRL_LAST);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == SYNC_BYTE) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (hdr_done) begin
          if (too_long) begin
            phase_nxt = PH_HUNT;
          end else if (len_r == '0) begin
            phase_nxt = PH_TRAILER;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (body_done) begin
          phase_nxt = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        if (trl_done) begin
          phase_nxt = PH_HUNT;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  // Datapath and result.
  always_comb begin
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    crc_nxt    = crc_r;
    rcrc_nxt   = rcrc_r;
    tag_ok_nxt = tag_ok_r;
    seq_nxt    = seq_r;
    res_vld    = 1'b0;
    res        = '0;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == SYNC_BYTE) begin
          crc_nxt    = crc_feed('0, rx_byte);
          cnt_nxt    = HDR_TAG;
          len_nxt    = '0;
          rcrc_nxt   = '0;
          tag_ok_nxt = 1'b0;
          seq_nxt    = '0;
        end
      end
      PH_HEADER: begin
        case (cnt_r)
          HDR_TAG: begin
            tag_ok_nxt = (rx_byte == expected_tag);
            crc_nxt    = crc_byte;
          end
          HDR_LEN_HI: begin
            len_nxt = {rx_byte, len_r[BYTE_W-1:0]};
            crc_nxt = crc_byte;
          end
          HDR_LEN_LO: begin
            len_nxt = {len_r[LEN_W-1:BYTE_W], rx_byte};
            crc_nxt = crc_byte;
          end
          HDR_CRC_HI: begin
            rcrc_nxt = {rx_byte, rcrc_r[BYTE_W-1:0]};
            crc_nxt  = crc_feed(crc_r, '0);
          end
          default: begin
            rcrc_nxt = {rcrc_r[CRC_W-1:BYTE_W], rx_byte};
            crc_nxt  = crc_feed(crc_r, '0);
          end
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (hdr_done) begin
          if (too_long) begin
            res_vld    = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_TOO_LONG;
            res.length = len_r;
          end else begin
            // The body counts down from its length; the trailer counts up from zero.
            cnt_nxt = len_r;
          end
        end
      end
      PH_BODY: begin
        crc_nxt     = crc_byte;
        cnt_nxt     = cnt_r - 1'b1;
        res_vld     = 1'b1;
        res.kind    = KIND_BODY;
        res.payload = rx_byte;
      end
      PH_TRAILER: begin
        crc_nxt = crc_byte;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == TRL_SEQ) begin
          seq_nxt = rx_byte;
        end
        if (trl_done) begin
          res_vld    = 1'b1;
          res.kind   = KIND_STATUS;
          res.length = len_r;
          res.seq    = seq_r;
          if (!tag_ok_r) begin
            res.status = ST_WRONG_TAG;
          end else if (crc_byte != rcrc_r) begin
            res.status = ST_CRC_MISMATCH;
          end else begin
            res.status = ST_OK;
          end
        end
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      rcrc_r   <= rcrc_nxt;
      tag_ok_r <= tag_ok_nxt;
      seq_r    <= seq_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_body_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && (res.kind == KIND_BODY) |-> phase_r == PH_BODY)
    else $error("body byte result outside the body phase");

  a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> (cnt_r >= HDR_TAG) && (cnt_r <= HDR_CRC_LO))
    else $error("header byte counter out of range");

  a_trailer_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_TRAILER |-> cnt_r <= TRL_LAST)
    else $error("trailer byte counter out of range");

  a_body_to_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_BODY) && body_done |=> phase_r == PH_TRAILER && cnt_r == '0)
    else $error("last body byte did not lead into the trailer");
`endif

endmodule

### src/slcfr_out_reg.sv
// Result register of the sync, length and CRC frame receiver.
// Holds one finished result until the downstream side takes it; depends on slcfr_pkg.
`timescale 1ns / 1ps

module slcfr_out_reg
  import slcfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_vld,
  output result_t out_res
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_vld = vld_r;
  assign out_res = res_r;

endmodule
